/* rtl/core/gsa_pkg.sv */
package gsa_pkg;

    // command codes
    localparam logic [2:0] OP_WR_A    = 3'd0;
    localparam logic [2:0] OP_WR_B    = 3'd1;
    localparam logic [2:0] OP_WR_C    = 3'd2;
    localparam logic [2:0] OP_COMPUTE = 3'd3;
    localparam logic [2:0] OP_RD_C    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_TRANS_A = 3'd0;
    localparam logic [2:0] CFG_TRANS_B = 3'd1;
    localparam logic [2:0] CFG_ROWS_M  = 3'd2;
    localparam logic [2:0] CFG_COLS_N  = 3'd3;
    localparam logic [2:0] CFG_INNER_K = 3'd4;
    localparam logic [2:0] CFG_ALPHA   = 3'd5;
    localparam logic [2:0] CFG_BETA    = 3'd6;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] q16_t;

    // floor shift of a Q32.32 product to Q16.16, saturated to 32 bits
    function automatic q16_t sat_q16(input logic signed [63:0] p);
        logic [16:0] hi;
        begin
            hi = p[63:47];
            if ((&hi) || !(|hi))
                return p[47:16];
            else if (p[63])
                return Q_MIN;
            else
                return Q_MAX;
        end
    endfunction

    // saturating add of two Q16.16 values
    function automatic q16_t sat_add(input q16_t x, input q16_t y);
        logic signed [32:0] s;
        begin
            s = {x[31], x} + {y[31], y};
            if (s[32] != s[31])
                return s[32] ? Q_MIN : Q_MAX;
            else
                return s[31:0];
        end
    endfunction

endpackage

/* rtl/core/gsa_ram.sv */
module gsa_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/gemm_scaled_accumulate.sv */
// element writes: one request per cycle while the block is idle and the output is not stalled, no result
// read of C: result is loaded into the output register in the cycle after the request is taken,
//   and the next request is taken once the block is back in idle and the output is not stalled
// compute: dims clamped to MAX_DIM; each C entry steps through dot product, saturate, alpha
//   multiply, beta multiply and write-back, using the shared 32x32 multiplier and the
//   single read port of each element store; reset: registers return to trans 0, dims 16,
//   alpha 1.0, beta 0; the stores are not cleared
module gemm_scaled_accumulate #(
    parameter int MAX_DIM = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // command channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [3:0]          row_index,
    input  logic [3:0]          col_index,
    input  logic signed [31:0]  element_value,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic signed [31:0]  read_value
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = 64 + $clog2(MAX_DIM) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDATA,
        ST_DOT,
        ST_SAT,
        ST_MULA,
        ST_MULB,
        ST_WB,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic        trans_a_reg;
    logic        trans_b_reg;
    logic [4:0]  rows_m_reg;
    logic [4:0]  cols_n_reg;
    logic [4:0]  inner_k_reg;
    gsa_pkg::q16_t alpha_reg;
    gsa_pkg::q16_t beta_reg;

    // compute loop
    logic [4:0]  m_reg, n_reg, kk_reg;
    logic [4:0]  i_reg, j_reg, k_reg;
    logic        rd_vld_reg;
    logic        prod_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0]      prod_reg;
    gsa_pkg::q16_t dot_reg;
    gsa_pkg::q16_t t1_reg;
    logic        rd_inside_reg;

    // output register
    logic          out_valid_reg;
    logic          kind_reg;
    gsa_pkg::q16_t value_reg;

    // memory ports
    logic [31:0]   a_rd, b_rd, c_rd;
    logic [AW-1:0] a_raddr, b_raddr, c_raddr, c_waddr;
    logic [31:0]   c_wdata;
    logic          a_we, b_we, c_we;

    logic          in_req;
    logic          out_req;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic [4:0]    m_clamp, n_clamp, k_clamp;
    gsa_pkg::q16_t dot_sat;
    gsa_pkg::q16_t t2;
    gsa_pkg::q16_t c_new;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_full;
    logic [ACC_W-48:0]  acc_hi;

    // handshakes
    assign out_req  = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_req   = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign read_value  = value_reg;

    // element address of the request
    assign in_inside = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign in_addr   = in_inside ? AW'(32'(row_index) * MAX_DIM + 32'(col_index)) : '0;

    // dimensions clamped to the store size
    assign m_clamp = (32'(rows_m_reg) > MAX_DIM)  ? 5'(MAX_DIM) : rows_m_reg;
    assign n_clamp = (32'(cols_n_reg) > MAX_DIM)  ? 5'(MAX_DIM) : cols_n_reg;
    assign k_clamp = (32'(inner_k_reg) > MAX_DIM) ? 5'(MAX_DIM) : inner_k_reg;

    // operand addresses for the inner product
    assign a_raddr = trans_a_reg ? AW'(32'(k_reg) * MAX_DIM + 32'(i_reg))
                                 : AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign b_raddr = trans_b_reg ? AW'(32'(j_reg) * MAX_DIM + 32'(k_reg))
                                 : AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));
    assign c_raddr = (state_reg == ST_IDLE) ? in_addr
                                            : AW'(32'(i_reg) * MAX_DIM + 32'(j_reg));

    // store writes from requests and from the write-back step
    assign a_we    = in_req && (opcode == gsa_pkg::OP_WR_A) && in_inside;
    assign b_we    = in_req && (opcode == gsa_pkg::OP_WR_B) && in_inside;
    assign c_we    = (in_req && (opcode == gsa_pkg::OP_WR_C) && in_inside)
                     || (state_reg == ST_WB);
    assign c_waddr = (state_reg == ST_WB) ? c_raddr : in_addr;
    assign c_wdata = (state_reg == ST_WB) ? c_new : element_value;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MULA:
            begin
                mul_a = alpha_reg;
                mul_b = dot_reg;
            end
            ST_MULB:
            begin
                mul_a = beta_reg;
                mul_b = c_rd;
            end
            default:
            begin
                mul_a = a_rd;
                mul_b = b_rd;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // product sum shifted to q16.16 and saturated
    assign acc_hi  = acc_reg[ACC_W-1:47];
    assign dot_sat = ((&acc_hi) || !(|acc_hi)) ? acc_reg[47:16]
                   : (acc_reg[ACC_W-1] ? gsa_pkg::Q_MIN : gsa_pkg::Q_MAX);

    // beta term and new C entry
    assign t2    = (beta_reg == '0) ? '0 : gsa_pkg::sat_q16(prod_reg);
    assign c_new = gsa_pkg::sat_add(t1_reg, t2);

    gsa_ram #(.DEPTH(DEPTH), .AW(AW)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (in_addr),
        .wdata (element_value),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    gsa_ram #(.DEPTH(DEPTH), .AW(AW)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (in_addr),
        .wdata (element_value),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    gsa_ram #(.DEPTH(DEPTH), .AW(AW)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rd)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_a_reg <= 1'b0;
            trans_b_reg <= 1'b0;
            rows_m_reg  <= 5'd16;
            cols_n_reg  <= 5'd16;
            inner_k_reg <= 5'd16;
            alpha_reg   <= 32'sh0001_0000;
            beta_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gsa_pkg::CFG_TRANS_A: trans_a_reg <= cfg_data[0];
                gsa_pkg::CFG_TRANS_B: trans_b_reg <= cfg_data[0];
                gsa_pkg::CFG_ROWS_M:  rows_m_reg  <= cfg_data[4:0];
                gsa_pkg::CFG_COLS_N:  cols_n_reg  <= cfg_data[4:0];
                gsa_pkg::CFG_INNER_K: inner_k_reg <= cfg_data[4:0];
                gsa_pkg::CFG_ALPHA:   alpha_reg   <= cfg_data;
                gsa_pkg::CFG_BETA:    beta_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= gsa_pkg::KIND_READ;
            value_reg     <= '0;
            m_reg         <= '0;
            n_reg         <= '0;
            kk_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            dot_reg       <= '0;
            t1_reg        <= '0;
            rd_inside_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_full;
            if (out_req)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_req && opcode == gsa_pkg::OP_RD_C)
                    begin
                        rd_inside_reg <= in_inside;
                        state_reg     <= ST_RDATA;
                    end
                    else if (in_req && opcode == gsa_pkg::OP_COMPUTE)
                    begin
                        m_reg        <= m_clamp;
                        n_reg        <= n_clamp;
                        kk_reg       <= k_clamp;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        k_reg        <= '0;
                        acc_reg      <= '0;
                        rd_vld_reg   <= 1'b0;
                        prod_vld_reg <= 1'b0;
                        if (m_clamp == '0 || n_clamp == '0)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_DOT;
                    end
                end
                ST_RDATA:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= gsa_pkg::KIND_READ;
                    value_reg     <= rd_inside_reg ? c_rd : '0;
                    state_reg     <= ST_IDLE;
                end
                ST_DOT:
                begin
                    // issue, multiply and accumulate overlap one step apart
                    if (k_reg != kk_reg)
                        k_reg <= k_reg + 5'd1;
                    rd_vld_reg   <= (k_reg != kk_reg);
                    prod_vld_reg <= rd_vld_reg;
                    if (prod_vld_reg)
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (k_reg == kk_reg && !rd_vld_reg && !prod_vld_reg)
                        state_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    dot_reg   <= dot_sat;
                    state_reg <= ST_MULA;
                end
                ST_MULA:
                begin
                    state_reg <= ST_MULB;
                end
                ST_MULB:
                begin
                    t1_reg    <= gsa_pkg::sat_q16(prod_reg);
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    k_reg   <= '0;
                    acc_reg <= '0;
                    if (j_reg + 5'd1 == n_reg)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 5'd1;
                        if (i_reg + 5'd1 == m_reg)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_DOT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 5'd1;
                        state_reg <= ST_DOT;
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= gsa_pkg::KIND_DONE;
                    value_reg     <= '0;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a compute request starts the product loop or finishes at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_req && opcode == gsa_pkg::OP_COMPUTE
        |=> state_reg == ST_DOT || state_reg == ST_DONE)
        else $error("compute request did not start the sequencer");

    // the output register is free whenever a result is about to be loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA || state_reg == ST_DONE) |-> !out_valid_reg)
        else $error("result would overwrite a pending result");

    // products only flow while the inner loop runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || prod_vld_reg) |-> state_reg == ST_DOT)
        else $error("product pipeline active outside the inner loop");

    // the inner counter never passes the clamped inner dimension
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DOT |-> k_reg <= kk_reg)
        else $error("inner counter overran");

    // a finished compute carries zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == gsa_pkg::KIND_DONE |-> read_value == '0)
        else $error("compute result with nonzero data");

endmodule

/* sim/tb_gemm_scaled_accumulate.sv */
`timescale 1ns / 100ps

module tb_gemm_scaled_accumulate;

    localparam int DIM = 16;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] CFG_UNMAPPED    = 3'd7;
    localparam gsa_pkg::q16_t Q_ONE = 32'sh0001_0000;
    localparam logic signed [79:0] WIDE_MAX = 80'sd2147483647;
    localparam logic signed [79:0] WIDE_MIN = -80'sd2147483648;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 64;
    localparam int PRINT_CAP = 100;

    typedef struct {
        logic kind;
        gsa_pkg::q16_t value;
    } gemm_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [2:0] opcode;
    logic [3:0] row_index;
    logic [3:0] col_index;
    logic signed [31:0] element_value;
    logic out_valid;
    logic out_stall;
    logic result_kind;
    logic signed [31:0] read_value;

    // shadow copy of the stores and registers
    gsa_pkg::q16_t shadow_a [DIM*DIM];
    gsa_pkg::q16_t shadow_b [DIM*DIM];
    gsa_pkg::q16_t shadow_c [DIM*DIM];
    logic trans_a_q;
    logic trans_b_q;
    logic [4:0] rows_q;
    logic [4:0] cols_q;
    logic [4:0] inner_q;
    gsa_pkg::q16_t alpha_q;
    gsa_pkg::q16_t beta_q;

    gemm_result_t awaited_results [$];
    int error_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    gemm_scaled_accumulate #(.MAX_DIM(DIM)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .row_index(row_index),
        .col_index(col_index),
        .element_value(element_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .read_value(read_value)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic gsa_pkg::q16_t saturate32(input logic signed [79:0] x);
        if (x > WIDE_MAX)
            return gsa_pkg::Q_MAX;
        if (x < WIDE_MIN)
            return gsa_pkg::Q_MIN;
        return x[31:0];
    endfunction

    function automatic int clamp_dim(input logic [4:0] v);
        return (v > DIM) ? DIM : int'(v);
    endfunction

    // exact sum of Q32.32 products, floor shifted back to Q16.16
    function automatic gsa_pkg::q16_t dot_row_col(input int i, input int j, input int depth);
        logic signed [79:0] acc;
        logic signed [79:0] av;
        logic signed [79:0] bv;
        int ai;
        int bi;
        int k;
        acc = '0;
        for (k = 0; k < depth; k++)
        begin
            ai = trans_a_q ? k * DIM + i : i * DIM + k;
            bi = trans_b_q ? j * DIM + k : k * DIM + j;
            av = shadow_a[ai];
            bv = shadow_b[bi];
            acc = acc + av * bv;
        end
        return saturate32(acc >>> 16);
    endfunction

    // C = alpha*op(A)*op(B) + beta*C over the active block
    function automatic void run_compute();
        int m;
        int n;
        int depth;
        int i;
        int j;
        logic signed [79:0] sum_w;
        logic signed [79:0] gain_w;
        logic signed [79:0] old_w;
        logic signed [79:0] t1;
        logic signed [79:0] t2;
        m = clamp_dim(rows_q);
        n = clamp_dim(cols_q);
        depth = clamp_dim(inner_q);
        for (i = 0; i < m; i++)
        begin
            for (j = 0; j < n; j++)
            begin
                sum_w = dot_row_col(i, j, depth);
                gain_w = alpha_q;
                t1 = saturate32((gain_w * sum_w) >>> 16);
                t2 = '0;
                // zero beta never looks at old C
                if (beta_q != 0)
                begin
                    gain_w = beta_q;
                    old_w = shadow_c[i * DIM + j];
                    t2 = saturate32((gain_w * old_w) >>> 16);
                end
                shadow_c[i * DIM + j] = saturate32(t1 + t2);
            end
        end
    endfunction

    function automatic void predict_request(input logic [2:0] op, input logic [3:0] row,
                                            input logic [3:0] col, input gsa_pkg::q16_t val);
        gemm_result_t res;
        case (op)
            gsa_pkg::OP_WR_A: shadow_a[{row, col}] = val;
            gsa_pkg::OP_WR_B: shadow_b[{row, col}] = val;
            gsa_pkg::OP_WR_C: shadow_c[{row, col}] = val;
            gsa_pkg::OP_COMPUTE:
            begin
                run_compute();
                res.kind = gsa_pkg::KIND_DONE;
                res.value = '0;
                awaited_results.push_back(res);
            end
            gsa_pkg::OP_RD_C:
            begin
                res.kind = gsa_pkg::KIND_READ;
                res.value = shadow_c[{row, col}];
                awaited_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        gemm_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d value %h",
                                          result_kind, read_value));
            else
            begin
                exp_res = awaited_results.pop_front();
                if (result_kind !== exp_res.kind)
                    report_mismatch($sformatf("result_kind %0d, wanted %0d",
                                              result_kind, exp_res.kind));
                if (read_value !== exp_res.value)
                    report_mismatch($sformatf("read_value %h, wanted %h",
                                              read_value, exp_res.value));
            end
        end
    end

    // one request, with random idle cycles in front of it
    task automatic send_request(input logic [2:0] op, input logic [3:0] row,
                                input logic [3:0] col, input gsa_pkg::q16_t val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        row_index <= row;
        col_index <= col;
        element_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(op, row, col, val);
    endtask

    // hold off requests until every awaited result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_register(input logic [2:0] index, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        case (index)
            gsa_pkg::CFG_TRANS_A: trans_a_q = data[0];
            gsa_pkg::CFG_TRANS_B: trans_b_q = data[0];
            gsa_pkg::CFG_ROWS_M:  rows_q = data[4:0];
            gsa_pkg::CFG_COLS_N:  cols_q = data[4:0];
            gsa_pkg::CFG_INNER_K: inner_q = data[4:0];
            gsa_pkg::CFG_ALPHA:   alpha_q = data;
            gsa_pkg::CFG_BETA:    beta_q = data;
            default: ;
        endcase
    endtask

    // random junk above a narrow register field, half of the time
    function automatic logic [31:0] pad_field(input logic [31:0] field, input int width);
        logic [31:0] noise;
        noise = $urandom();
        noise = noise << width;
        return $urandom_range(1) ? (noise | field) : field;
    endfunction

    task automatic set_dims(input logic [4:0] m, input logic [4:0] n, input logic [4:0] k);
        write_register(gsa_pkg::CFG_ROWS_M, pad_field(m, 5));
        write_register(gsa_pkg::CFG_COLS_N, pad_field(n, 5));
        write_register(gsa_pkg::CFG_INNER_K, pad_field(k, 5));
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic ta, input logic tb, input logic [4:0] m,
                             input logic [4:0] n, input logic [4:0] k,
                             input gsa_pkg::q16_t alpha, input gsa_pkg::q16_t beta,
                             input logic poke_unmapped);
        drain_results();
        // let trailing element writes settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (poke_unmapped)
            write_register(CFG_UNMAPPED, $urandom());
        write_register(gsa_pkg::CFG_TRANS_A, pad_field(ta, 1));
        write_register(gsa_pkg::CFG_TRANS_B, pad_field(tb, 1));
        write_register(gsa_pkg::CFG_ALPHA, alpha);
        write_register(gsa_pkg::CFG_BETA, beta);
        set_dims(m, n, k);
    endtask

    function automatic gsa_pkg::q16_t pick_element();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return gsa_pkg::Q_MAX;
        if (r < 10)
            return gsa_pkg::Q_MIN;
        if (r < 13)
            return '0;
        if (r < 16)
            return -1;
        if (r < 20)
            return Q_ONE;
        if (r < 60)
            return gsa_pkg::q16_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        return $urandom();
    endfunction

    function automatic gsa_pkg::q16_t pick_gain(input int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return '0;
        r = $urandom_range(99);
        if (r < 12)
            return gsa_pkg::Q_MAX;
        if (r < 24)
            return gsa_pkg::Q_MIN;
        if (r < 40)
            return Q_ONE;
        if (r < 48)
            return -Q_ONE;
        if (r < 80)
            return gsa_pkg::q16_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        return $urandom();
    endfunction

    // mostly small sizes, sometimes empty, full or oversized
    function automatic logic [4:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 5'd0;
        if (r < 12)
            return 5'd16;
        if (r < 18)
            return 5'($urandom_range(31, 17));
        return 5'($urandom_range(4, 1));
    endfunction

    // 2x2 block with extreme elements, reset gains, unused opcodes, C round trip
    task automatic test_directed_extremes();
        int rc;
        int u;
        set_dims(5'd2, 5'd2, 5'd2);
        send_request(gsa_pkg::OP_WR_A, 4'd0, 4'd0, gsa_pkg::Q_MAX);
        send_request(gsa_pkg::OP_WR_A, 4'd0, 4'd1, gsa_pkg::Q_MAX);
        send_request(gsa_pkg::OP_WR_A, 4'd1, 4'd0, gsa_pkg::Q_MIN);
        send_request(gsa_pkg::OP_WR_A, 4'd1, 4'd1, Q_ONE);
        send_request(gsa_pkg::OP_WR_B, 4'd0, 4'd0, gsa_pkg::Q_MAX);
        send_request(gsa_pkg::OP_WR_B, 4'd1, 4'd0, gsa_pkg::Q_MAX);
        send_request(gsa_pkg::OP_WR_B, 4'd0, 4'd1, -1);
        send_request(gsa_pkg::OP_WR_B, 4'd1, 4'd1, gsa_pkg::Q_MIN);
        send_request(gsa_pkg::OP_COMPUTE, 4'd15, 4'd15, gsa_pkg::Q_MIN);
        for (rc = 0; rc < 4; rc++)
            send_request(gsa_pkg::OP_RD_C, 4'(rc / 2), 4'(rc % 2), '0);
        // unused opcodes give nothing back
        for (u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++)
            send_request(3'(u), 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom());
        send_request(gsa_pkg::OP_WR_C, 4'd15, 4'd15, gsa_pkg::Q_MIN);
        send_request(gsa_pkg::OP_RD_C, 4'd15, 4'd15, gsa_pkg::Q_MAX);
        send_request(gsa_pkg::OP_WR_C, 4'd15, 4'd0, -1);
        send_request(gsa_pkg::OP_RD_C, 4'd15, 4'd0, '0);
    endtask

    // transposes, extreme gains, empty inner range, empty row range
    task automatic test_directed_gains();
        configure(1'b1, 1'b1, 5'd2, 5'd2, 5'd2, gsa_pkg::Q_MIN, gsa_pkg::Q_MAX, 1'b1);
        send_request(gsa_pkg::OP_COMPUTE, 4'd0, 4'd0, '0);
        send_request(gsa_pkg::OP_RD_C, 4'd0, 4'd0, '0);
        send_request(gsa_pkg::OP_RD_C, 4'd1, 4'd1, '0);
        // inner range empty: only the beta term is left
        configure(1'b0, 1'b1, 5'd2, 5'd2, 5'd0, Q_ONE, gsa_pkg::Q_MIN, 1'b0);
        send_request(gsa_pkg::OP_COMPUTE, 4'd0, 4'd0, '0);
        send_request(gsa_pkg::OP_RD_C, 4'd0, 4'd1, '0);
        // no rows: C untouched
        configure(1'b1, 1'b0, 5'd0, 5'd2, 5'd2, gsa_pkg::Q_MAX, Q_ONE, 1'b0);
        send_request(gsa_pkg::OP_COMPUTE, 4'd0, 4'd0, '0);
        send_request(gsa_pkg::OP_RD_C, 4'd1, 4'd0, '0);
    endtask

    // fill A and B completely, one compute with oversized dims fills all of C
    task automatic test_full_size();
        int idx;
        configure(1'($urandom_range(1)), 1'($urandom_range(1)), 5'd31, 5'd16, 5'd24,
                  pick_gain(0), '0, 1'b0);
        for (idx = 0; idx < DIM * DIM; idx++)
            send_request(gsa_pkg::OP_WR_A, 4'(idx / DIM), 4'(idx % DIM), pick_element());
        for (idx = 0; idx < DIM * DIM; idx++)
            send_request(gsa_pkg::OP_WR_B, 4'(idx / DIM), 4'(idx % DIM), pick_element());
        send_request(gsa_pkg::OP_COMPUTE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     $urandom());
        repeat (8)
            send_request(gsa_pkg::OP_RD_C, 4'($urandom_range(15)), 4'($urandom_range(15)),
                         $urandom());
    endtask

    // random mix of writes, computes and reads under a new setting per phase
    task automatic test_random_traffic(input int phases, input int per_phase);
        int p;
        int i;
        int r;
        int cost;
        int computes_left;
        logic [3:0] row;
        logic [3:0] col;
        logic [4:0] m;
        logic [4:0] n;
        logic [4:0] k;
        gsa_pkg::q16_t alpha;
        gsa_pkg::q16_t beta;
        for (p = 0; p < phases; p++)
        begin
            if (p < phases / 3)
            begin
                sender_idle_pct = 26;
                receiver_stall_pct = 46;
            end
            else if (p < 2 * phases / 3)
            begin
                sender_idle_pct = 46;
                receiver_stall_pct = 26;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            if (p == 0)
                configure(1'b1, 1'b0, 5'd1, 5'd1, 5'd1, gsa_pkg::Q_MAX, gsa_pkg::Q_MIN, 1'b0);
            else if (p == 1)
                configure(1'b0, 1'b1, 5'd16, 5'd16, 5'd16, gsa_pkg::Q_MIN, gsa_pkg::Q_MAX,
                          1'b0);
            else
            begin
                m = pick_dim();
                n = pick_dim();
                k = pick_dim();
                alpha = pick_gain(5);
                beta = pick_gain(25);
                configure(1'($urandom_range(1)), 1'($urandom_range(1)), m, n, k,
                          alpha, beta, 1'b0);
            end
            // keep slow computes rare
            cost = 2 + clamp_dim(rows_q) * clamp_dim(cols_q) * (clamp_dim(inner_q) + 7);
            computes_left = (cost > 300) ? 2 : per_phase;
            for (i = 0; i < per_phase; i++)
            begin
                r = $urandom_range(99);
                row = 4'($urandom_range(15));
                col = 4'($urandom_range(15));
                if (r < 20)
                    send_request(gsa_pkg::OP_WR_A, row, col, pick_element());
                else if (r < 40)
                    send_request(gsa_pkg::OP_WR_B, row, col, pick_element());
                else if (r < 50)
                    send_request(gsa_pkg::OP_WR_C, row, col, pick_element());
                else if (r < 62 && computes_left > 0)
                begin
                    computes_left--;
                    send_request(gsa_pkg::OP_COMPUTE, row, col, $urandom());
                end
                else if (r < 95)
                    send_request(gsa_pkg::OP_RD_C, row, col, $urandom());
                else
                    send_request(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                                 row, col, $urandom());
                // occasional full pause until the result side is empty
                if ($urandom_range(99) == 0)
                    drain_results();
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= gsa_pkg::CFG_TRANS_A;
        cfg_data <= '0;
        in_valid <= 1'b0;
        opcode <= gsa_pkg::OP_WR_A;
        row_index <= '0;
        col_index <= '0;
        element_value <= '0;
        trans_a_q = 1'b0;
        trans_b_q = 1'b0;
        rows_q = 5'd16;
        cols_q = 5'd16;
        inner_q = 5'd16;
        alpha_q = Q_ONE;
        beta_q = '0;
        sender_idle_pct = 26;
        receiver_stall_pct = 46;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_directed_gains();
        test_full_size();
        test_random_traffic(14, 100);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
